@@ rtl/core/sba_pkg.sv @@
// Shared types, codes and helpers of the sector bitmap allocator.
package sba_pkg;

  // Map geometry and register defaults
  localparam int MAX_SECTORS_DEF     = 2048;
  localparam int WORD_W              = 32;
  localparam int OFF_W               = 5;
  localparam int COUNT_W             = 12;
  localparam int SECTOR_W            = 11;
  localparam int APB_AW              = 3;
  localparam int APB_DW              = 32;
  localparam logic [COUNT_W-1:0] SECTOR_COUNT_RESET = 12'd1440;
  localparam logic [APB_AW-1:0]  ADDR_SECTOR_COUNT  = 3'd0;

  // Command codes
  localparam logic [1:0] CMD_FIND    = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } sba_state_e;

  // Input word
  typedef struct packed {
    logic [1:0]          command;
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  run_length;
  } sba_cmd_t;

  // Result word
  typedef struct packed {
    logic                found;
    logic [SECTOR_W-1:0] sector;
  } sba_result_t;

  // Per-word operation handed to the word unit
  typedef struct packed {
    logic [1:0]       command;
    logic             lo_edge;
    logic [OFF_W-1:0] lo_off;
    logic             hi_edge;
    logic [OFF_W-1:0] hi_off;
  } sba_op_t;

  // Word unit answer
  typedef struct packed {
    logic              hit;
    logic [OFF_W-1:0]  bit_idx;
    logic [WORD_W-1:0] wdata;
  } sba_ures_t;

  // Index of the lowest set bit of a map word
  function automatic logic [OFF_W-1:0] low_index(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/sba_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sba_word_unit.sv @@
// Shared word unit: builds the sector mask, searches free bits, forms the updated word.
module sba_word_unit
  import sba_pkg::*;
(
  input  logic [WORD_W-1:0] rdata_i,
  input  sba_op_t           op_i,
  output sba_ures_t         res_o
);

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] free_bits;

  // Keep only the sectors of this word that fall in [lo, limit)
  assign lo_mask   = op_i.lo_edge ? ({WORD_W{1'b1}} << op_i.lo_off) : {WORD_W{1'b1}};
  assign hi_mask   = op_i.hi_edge ? ~({WORD_W{1'b1}} << op_i.hi_off) : {WORD_W{1'b1}};
  assign mask      = lo_mask & hi_mask;
  assign free_bits = ~rdata_i & mask;

  // Search for the first free sector and form the read-modify-write word
  always_comb begin
    res_o.hit     = |free_bits;
    res_o.bit_idx = low_index(free_bits);
    if (op_i.command == CMD_ALLOC) begin
      res_o.wdata = rdata_i | mask;
    end else begin
      res_o.wdata = rdata_i & ~mask;
    end
  end

endmodule

@@ rtl/core/sba_seq.sv @@
// Sequencer: clearing sweep, word walk over the map, and result register.
module sba_seq
  import sba_pkg::*;
#(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  localparam int WORDS      = (MAX_SECTORS + WORD_W - 1) / WORD_W,
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int SECW       = ($clog2(MAX_SECTORS + 1) > 13) ? $clog2(MAX_SECTORS + 1) : 13,
  localparam int WNW        = SECW - OFF_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sba_cmd_t           cmd_i,
  input  logic [COUNT_W-1:0] sector_count_i,
  output logic               busy_o,
  output logic               done_o,
  output sba_result_t        result_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [WORD_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  output sba_op_t            op_o,
  input  sba_ures_t          ures_i
);

  localparam logic [SECW-1:0] MAX_S     = SECW'(MAX_SECTORS);
  localparam logic [WNW-1:0]  LAST_WORD = WNW'(WORDS - 1);

  sba_state_e state_q, state_d;
  logic [1:0]      cmd_q,    cmd_d;
  logic [SECW-1:0] lo_q,     lo_d;
  logic [SECW-1:0] lim_q,    lim_d;
  logic [WNW-1:0]  last_w_q, last_w_d;
  logic [WNW-1:0]  rd_w_q,   rd_w_d;
  logic [WNW-1:0]  pw_q,     pw_d;
  logic            pend_q,   pend_d;
  logic            done_q,   done_d;
  sba_result_t     res_q,    res_d;

  logic            accept;
  logic            cmd_valid;
  logic [SECW-1:0] lo_new;
  logic [SECW-1:0] cnt_ext;
  logic [SECW-1:0] run_end;
  logic [SECW-1:0] lim_new;
  logic [SECW-1:0] lim_m1;
  logic            empty;
  logic            issue;
  logic            is_last;
  logic            fin;
  logic [SECW-1:0] hit_sec;

  // Decode an incoming command into its sector window
  assign accept    = start_i && (state_q == ST_IDLE);
  assign cmd_valid = (cmd_i.command != CMD_NONE);
  assign lo_new    = SECW'(cmd_i.start_sector);
  assign cnt_ext   = SECW'(sector_count_i);
  assign run_end   = SECW'(cmd_i.start_sector) + SECW'(cmd_i.run_length);
  always_comb begin
    if (cmd_i.command == CMD_FIND) begin
      lim_new = (cnt_ext < MAX_S) ? cnt_ext : MAX_S;
    end else begin
      lim_new = (run_end < MAX_S) ? run_end : MAX_S;
    end
  end
  assign empty  = (lo_new >= lim_new);
  assign lim_m1 = lim_new - SECW'(1);

  // Word walk status
  assign issue   = (rd_w_q <= last_w_q);
  assign is_last = (pw_q == last_w_q);
  assign fin     = (state_q == ST_RUN) && pend_q &&
                   (is_last || ((cmd_q == CMD_FIND) && ures_i.hit));
  assign hit_sec = {pw_q, ures_i.bit_idx};

  // Operation for the word now returning from the map
  assign op_o.command = cmd_q;
  assign op_o.lo_edge = (pw_q == lo_q[SECW-1:OFF_W]);
  assign op_o.lo_off  = lo_q[OFF_W-1:0];
  assign op_o.hi_edge = (pw_q == lim_q[SECW-1:OFF_W]);
  assign op_o.hi_off  = lim_q[OFF_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (rd_w_q == LAST_WORD) state_d = ST_IDLE;
      ST_IDLE:  if (accept && cmd_valid && !empty) state_d = ST_RUN;
      ST_RUN:   if (fin) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    lim_d       = lim_q;
    last_w_d    = last_w_q;
    rd_w_d      = rd_w_q;
    pw_d        = pw_q;
    pend_d      = 1'b0;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pw_q[AW-1:0];
    ram_wdata_o = ures_i.wdata;
    ram_raddr_o = rd_w_q[AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the map, one word a cycle
        ram_we_o    = 1'b1;
        ram_waddr_o = rd_w_q[AW-1:0];
        ram_wdata_o = '0;
        rd_w_d      = rd_w_q + WNW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i.command;
          lo_d     = lo_new;
          lim_d    = lim_new;
          last_w_d = lim_m1[SECW-1:OFF_W];
          rd_w_d   = lo_new[SECW-1:OFF_W];
          if (!cmd_valid || empty) begin
            // Answer at once: nothing to walk
            done_d       = 1'b1;
            res_d.found  = (cmd_i.command == CMD_ALLOC) || (cmd_i.command == CMD_RELEASE);
            res_d.sector = (cmd_i.command == CMD_FIND) ? '0 : cmd_i.start_sector;
          end
        end
      end
      ST_RUN: begin
        // Issue the next read while the previous word is processed
        if (issue) begin
          pend_d = 1'b1;
          pw_d   = rd_w_q;
          rd_w_d = rd_w_q + WNW'(1);
        end
        if (pend_q) begin
          if (cmd_q != CMD_FIND) ram_we_o = 1'b1;
          if (fin) begin
            done_d = 1'b1;
            if (cmd_q == CMD_FIND) begin
              res_d.found  = ures_i.hit;
              res_d.sector = ures_i.hit ? hit_sec[SECTOR_W-1:0] : '0;
            end else begin
              res_d.found  = 1'b1;
              res_d.sector = lo_q[SECTOR_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      rd_w_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_w_q  <= rd_w_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    lo_q     <= lo_d;
    lim_q    <= lim_d;
    last_w_q <= last_w_d;
    pw_q     <= pw_d;
    res_q    <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // A result follows only a walk or a command taken in idle
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_RUN || (state_q == ST_IDLE && start_i)))
    else $error("result strobe without a command");

  // A find never writes the map
  a_find_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && ram_we_o) |-> (cmd_q == CMD_ALLOC || cmd_q == CMD_RELEASE))
    else $error("map written during find");

  // Read pointer never passes one word beyond the window
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rd_w_q <= last_w_q + 1))
    else $error("read pointer past window");

  // Returning data is only expected while walking
  a_pend_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == ST_RUN))
    else $error("pending word outside a walk");
`endif

endmodule

@@ rtl/core/sector_bitmap_allocator.sv @@
// Top level of the sector bitmap allocator: APB register, sequencer, word unit, map RAM.
//
// Usage: drive cmd_i and raise start_i while busy_o is low; the word is taken at that
// clock edge. Commands: find first free sector from start_sector below sector_count,
// allocate a run, release a run. Each command yields one result word on result_o,
// marked by done_o for exactly one cycle; the receiver cannot stall it, so it must
// take the word in that cycle.
// Walk: a command reads each map word it touches (32 sectors each) in turn through the
// registered RAM read and the word unit, and its result is registered for done_o; a
// find stops at the first word holding a free sector. Commands with an empty window,
// zero-length runs and the unused code answer in the cycle after acceptance. busy_o is
// high from acceptance until the walk ends, so one command runs at a time; the rate
// is set by the single read port of the map, one word per cycle.
// Reset: the map is swept to all free, one word per cycle, over MAX_SECTORS/32 words
// (64 by default); busy_o stays high meanwhile. The APB register sector_count
// (address 0, reset 1440) may be written at any time the block is idle; pready is
// always high.
module sector_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              start_i,
  input  sba_cmd_t          cmd_i,
  output logic              busy_o,
  output logic              done_o,
  output sba_result_t       result_o
);

  localparam int WORDS = (MAX_SECTORS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [COUNT_W-1:0] sector_count_q;
  logic               cfg_we;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  sba_op_t            op;
  sba_ures_t          ures;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_SECTOR_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q <= SECTOR_COUNT_RESET;
    end else if (cfg_we) begin
      sector_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Read back
  assign prdata = (paddr == ADDR_SECTOR_COUNT) ? APB_DW'(sector_count_q) : '0;

  sba_seq #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .sector_count_i (sector_count_q),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .result_o       (result_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .op_o           (op),
    .ures_i         (ures)
  );

  sba_word_unit u_word_unit (
    .rdata_i (ram_rdata),
    .op_i    (op),
    .res_o   (ures)
  );

  sba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
